FILE: rtl/core/sgm_pkg.sv
// Shared constants, types and functions of the Sobel gradient magnitude core.
package sgm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W  = 8;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 11;
  localparam int IDX_W  = 2;
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int LINE_W = 3 * PIX_W;

  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = IDX_W'(1);

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // Division by three of a value below 768 as a multiply by 683 and a shift by 11.
  localparam int GRAY_SUM_W = 10;
  localparam int GRAY_MUL_W = 20;
  localparam logic [GRAY_MUL_W-1:0] GRAY_RECIP = GRAY_MUL_W'(683);
  localparam int GRAY_SHIFT = 11;

  localparam int GRAD_W = 11;
  localparam int SQ_W   = 20;
  localparam int SUM_W  = 21;
  localparam int ROOT_IN_W = 16;
  localparam int REM_W  = 10;

  // Smallest sum whose rounded root exceeds 255.
  localparam logic [SUM_W-1:0] ROOT_SAT = SUM_W'(65281);
  localparam logic [PIX_W-1:0] MAG_MAX  = 8'hFF;

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] center_alpha;
    logic             frame_end;
  } meta_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [PIX_W-1:0] root;
  } root_state_t;

  // Clamps a configured size to 3..max and returns the index of the last position.
  function automatic logic [POS_W-1:0] last_index(logic [CFG_W-1:0] size, int max_size);
    logic [CFG_W-1:0] lim;
    lim = CFG_W'(max_size);
    if (size < CFG_W'(3)) begin
      return POS_W'(2);
    end else if (size > lim) begin
      return POS_W'(lim - CFG_W'(1));
    end else begin
      return POS_W'(size - CFG_W'(1));
    end
  endfunction

  // One restoring square-root step that consumes the next two bits of the radicand.
  function automatic root_state_t root_step(root_state_t st, logic [1:0] pair);
    logic [REM_W+1:0] cand;
    logic [REM_W+1:0] trial;
    root_state_t      nx;
    cand  = {st.rem, pair};
    trial = (REM_W+2)'({st.root, 2'b01});
    if (cand >= trial) begin
      nx.rem  = REM_W'(cand - trial);
      nx.root = {st.root[PIX_W-2:0], 1'b1};
    end else begin
      nx.rem  = cand[REM_W-1:0];
      nx.root = {st.root[PIX_W-2:0], 1'b0};
    end
    return nx;
  endfunction

endpackage

FILE: rtl/core/sgm_if.sv
// Handshake interfaces for the pixel, result and configuration channels.
interface sgm_pix_if;
  logic                     valid;
  logic                     ready;
  logic [sgm_pkg::PIX_W-1:0] red;
  logic [sgm_pkg::PIX_W-1:0] green;
  logic [sgm_pkg::PIX_W-1:0] blue;
  logic [sgm_pkg::PIX_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface sgm_res_if;
  logic                     valid;
  logic                     ready;
  logic [sgm_pkg::POS_W-1:0] column;
  logic [sgm_pkg::POS_W-1:0] row;
  logic [sgm_pkg::PIX_W-1:0] magnitude;
  logic [sgm_pkg::PIX_W-1:0] center_alpha;
  logic                     frame_end;

  modport source (output valid, column, row, magnitude, center_alpha, frame_end, input ready);
  modport sink   (input valid, column, row, magnitude, center_alpha, frame_end, output ready);
endinterface

interface sgm_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [sgm_pkg::IDX_W-1:0] index;
  logic [sgm_pkg::CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sobel_gradient_magnitude_core.sv
// Top level of the Sobel gradient magnitude core.
// The core takes one RGBA pixel per clock in raster order and returns, for each interior
// pixel, the rounded Sobel gradient magnitude of its gray 3x3 neighborhood with the
// center alpha; border pixels give no result. The pipeline is ten stages deep from an
// input transfer to the result; it stalls as a whole only while a result waits on the
// output, so the sustained rate is one pixel per clock. The two previous rows live in a
// 1024-entry line store RAM that is read when a pixel is taken and written back at the
// same column on the next cycle that the pipeline advances; it needs no clearing pass
// after reset. Frame size writes take effect at once and belong between frames.
module sobel_gradient_magnitude_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  sgm_pix_if.sink   pix_i,
  sgm_res_if.source res_o,
  sgm_cfg_if.sink   cfg_i
);

  logic [sgm_pkg::CFG_W-1:0] frame_width_q, frame_height_q;
  logic [sgm_pkg::POS_W-1:0] w_last, h_last;
  logic [sgm_pkg::POS_W-1:0] col_q, row_q;

  logic en, accept;

  // Stage A: gray value and position of the accepted pixel.
  logic                      a_vld_q;
  logic [sgm_pkg::PIX_W-1:0] a_gray_q, a_alpha_q;
  logic [sgm_pkg::POS_W-1:0] a_col_q;
  logic                      a_row0_q, a_emit_q, a_fend_q;
  logic [sgm_pkg::POS_W-1:0] a_out_col_q, a_out_row_q;
  logic [sgm_pkg::GRAY_SUM_W-1:0] gray_sum;
  logic [sgm_pkg::GRAY_MUL_W-1:0] gray_prod;

  // Line store access.
  logic [sgm_pkg::LINE_W-1:0] line_rdata, line_entry, line_wdata;
  logic                       line_we;
  logic [sgm_pkg::PIX_W-1:0]  g1, g2, a1;

  // Stage B: window state.
  logic [sgm_pkg::PIX_W-1:0] gw_q [3][3];
  logic [sgm_pkg::PIX_W-1:0] aw_q [3];
  logic                      b_vld_q;
  sgm_pkg::meta_t            b_meta_q;

  // Stage C: gradients.
  logic                             c_vld_q;
  logic signed [sgm_pkg::GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;
  logic [sgm_pkg::GRAD_W-2:0]       gx_pos, gx_neg, gy_pos, gy_neg;
  sgm_pkg::meta_t                   c_meta_q;

  // Stage D: squares. Stage E: sum of squares.
  logic                              d_vld_q, e_vld_q;
  logic signed [2*sgm_pkg::GRAD_W-1:0] sqx, sqy;
  logic [sgm_pkg::SQ_W-1:0]          sqx_q, sqy_q;
  logic [sgm_pkg::SUM_W-1:0]         e_sum_q;
  sgm_pkg::meta_t                    d_meta_q, e_meta_q;

  logic                      r_vld;
  logic [sgm_pkg::PIX_W-1:0] r_mag;
  sgm_pkg::meta_t            r_meta;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= sgm_pkg::WIDTH_RESET;
      frame_height_q <= sgm_pkg::HEIGHT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sgm_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data;
        sgm_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign w_last = sgm_pkg::last_index(frame_width_q, sgm_pkg::MAX_WIDTH);
  assign h_last = sgm_pkg::last_index(frame_height_q, sgm_pkg::MAX_HEIGHT);

  assign en          = !res_o.valid || res_o.ready;
  assign pix_i.ready = en;
  assign accept      = pix_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q >= w_last) begin
        col_q <= '0;
        row_q <= (row_q >= h_last) ? '0 : row_q + sgm_pkg::POS_W'(1);
      end else begin
        col_q <= col_q + sgm_pkg::POS_W'(1);
      end
    end
  end

  assign gray_sum  = sgm_pkg::GRAY_SUM_W'(pix_i.red) + sgm_pkg::GRAY_SUM_W'(pix_i.green) +
                     sgm_pkg::GRAY_SUM_W'(pix_i.blue) + sgm_pkg::GRAY_SUM_W'(1);
  assign gray_prod = sgm_pkg::GRAY_MUL_W'(gray_sum) * sgm_pkg::GRAY_RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_gray_q    <= gray_prod[sgm_pkg::GRAY_SHIFT +: sgm_pkg::PIX_W];
      a_alpha_q   <= pix_i.alpha;
      a_col_q     <= col_q;
      a_row0_q    <= (row_q == '0);
      a_emit_q    <= (row_q >= sgm_pkg::POS_W'(2)) && (col_q >= sgm_pkg::POS_W'(2));
      a_fend_q    <= (col_q >= w_last) && (row_q >= h_last);
      a_out_col_q <= col_q - sgm_pkg::POS_W'(1);
      a_out_row_q <= row_q - sgm_pkg::POS_W'(1);
    end
  end

  sgm_ram #(
    .DATA_W (sgm_pkg::LINE_W),
    .DEPTH  (sgm_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (a_col_q[sgm_pkg::ADDR_W-1:0]),
    .wdata_i (line_wdata),
    .re_i    (accept),
    .raddr_i (col_q[sgm_pkg::ADDR_W-1:0]),
    .rdata_o (line_rdata)
  );

  assign line_entry = a_row0_q ? '0 : line_rdata;
  assign g1         = line_entry[0 +: sgm_pkg::PIX_W];
  assign g2         = line_entry[sgm_pkg::PIX_W +: sgm_pkg::PIX_W];
  assign a1         = line_entry[2*sgm_pkg::PIX_W +: sgm_pkg::PIX_W];
  assign line_wdata = {a_alpha_q, g1, a_gray_q};
  assign line_we    = a_vld_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          gw_q[i][j] <= '0;
        end
        aw_q[i] <= '0;
      end
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q && a_emit_q;
      if (a_vld_q) begin
        for (int i = 0; i < 3; i++) begin
          gw_q[i][0] <= gw_q[i][1];
          gw_q[i][1] <= gw_q[i][2];
        end
        gw_q[0][2] <= g2;
        gw_q[1][2] <= g1;
        gw_q[2][2] <= a_gray_q;
        aw_q[0]    <= aw_q[1];
        aw_q[1]    <= aw_q[2];
        aw_q[2]    <= a1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_meta_q.column       <= a_out_col_q;
      b_meta_q.row          <= a_out_row_q;
      b_meta_q.center_alpha <= aw_q[2];
      b_meta_q.frame_end    <= a_fend_q;
    end
  end

  assign gx_pos = (sgm_pkg::GRAD_W-1)'(gw_q[0][2]) + (sgm_pkg::GRAD_W-1)'({gw_q[1][2], 1'b0}) +
                  (sgm_pkg::GRAD_W-1)'(gw_q[2][2]);
  assign gx_neg = (sgm_pkg::GRAD_W-1)'(gw_q[0][0]) + (sgm_pkg::GRAD_W-1)'({gw_q[1][0], 1'b0}) +
                  (sgm_pkg::GRAD_W-1)'(gw_q[2][0]);
  assign gy_pos = (sgm_pkg::GRAD_W-1)'(gw_q[0][0]) + (sgm_pkg::GRAD_W-1)'({gw_q[0][1], 1'b0}) +
                  (sgm_pkg::GRAD_W-1)'(gw_q[0][2]);
  assign gy_neg = (sgm_pkg::GRAD_W-1)'(gw_q[2][0]) + (sgm_pkg::GRAD_W-1)'({gw_q[2][1], 1'b0}) +
                  (sgm_pkg::GRAD_W-1)'(gw_q[2][2]);
  assign gx_d = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
  assign gy_d = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

  assign sqx = gx_q * gx_q;
  assign sqy = gy_q * gy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gx_q     <= gx_d;
      gy_q     <= gy_d;
      c_meta_q <= b_meta_q;
      sqx_q    <= sqx[sgm_pkg::SQ_W-1:0];
      sqy_q    <= sqy[sgm_pkg::SQ_W-1:0];
      d_meta_q <= c_meta_q;
      e_sum_q  <= sgm_pkg::SUM_W'(sqx_q) + sgm_pkg::SUM_W'(sqy_q);
      e_meta_q <= d_meta_q;
    end
  end

  sgm_root u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (e_vld_q),
    .sum_i  (e_sum_q),
    .meta_i (e_meta_q),
    .vld_o  (r_vld),
    .mag_o  (r_mag),
    .meta_o (r_meta)
  );

  assign res_o.valid        = r_vld;
  assign res_o.column       = r_meta.column;
  assign res_o.row          = r_meta.row;
  assign res_o.magnitude    = r_mag;
  assign res_o.center_alpha = r_meta.center_alpha;
  assign res_o.frame_end    = r_meta.frame_end;

`ifndef NO_ASSERTIONS
  a_line_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_we && accept) |-> (a_col_q != col_q))
    else $error("line store read and write hit the same column");

  a_emit_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && a_vld_q && a_emit_q) |=> b_vld_q)
    else $error("interior pixel did not reach the window stage");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(a_vld_q) && $stable(e_vld_q) && $stable(col_q)))
    else $error("pipeline moved while the output was stalled");

  a_result_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.column != '0 && res_o.row != '0))
    else $error("result issued for a border position");
`endif

endmodule

FILE: rtl/core/sgm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sgm_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sgm_root.sv
// Pipelined rounded square root, saturated at 255, with side data carried along.
module sgm_root (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [sgm_pkg::SUM_W-1:0]   sum_i,
  input  sgm_pkg::meta_t              meta_i,
  output logic                        vld_o,
  output logic [sgm_pkg::PIX_W-1:0]   mag_o,
  output sgm_pkg::meta_t              meta_o
);

  localparam int STAGES = 4;

  logic                           vld_q   [STAGES];
  logic                           sat_q   [STAGES];
  sgm_pkg::root_state_t           st_q    [STAGES];
  logic [sgm_pkg::ROOT_IN_W-1:0]  bits_q  [STAGES];
  sgm_pkg::meta_t                 meta_q  [STAGES];

  sgm_pkg::root_state_t           st_d    [STAGES];
  logic [sgm_pkg::ROOT_IN_W-1:0]  bits_d  [STAGES];
  logic                           sat_d   [STAGES];
  sgm_pkg::root_state_t           mid     [STAGES];

  logic                           out_vld_q;
  logic [sgm_pkg::PIX_W-1:0]      out_mag_q;
  sgm_pkg::meta_t                 out_meta_q;
  logic [sgm_pkg::PIX_W:0]        rounded;
  logic [sgm_pkg::PIX_W-1:0]      mag_d;

  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      sgm_pkg::root_state_t           src_st;
      logic [sgm_pkg::ROOT_IN_W-1:0]  src_bits;
      if (k == 0) begin
        src_st   = '0;
        src_bits = sum_i[sgm_pkg::ROOT_IN_W-1:0];
        sat_d[k] = (sum_i >= sgm_pkg::ROOT_SAT);
      end else begin
        src_st   = st_q[k-1];
        src_bits = bits_q[k-1];
        sat_d[k] = sat_q[k-1];
      end
      mid[k]    = sgm_pkg::root_step(src_st, src_bits[sgm_pkg::ROOT_IN_W-1 -: 2]);
      st_d[k]   = sgm_pkg::root_step(mid[k], src_bits[sgm_pkg::ROOT_IN_W-3 -: 2]);
      bits_d[k] = src_bits << 4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < STAGES; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_vld_q <= vld_q[STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < STAGES; k++) begin
        st_q[k]   <= st_d[k];
        bits_q[k] <= bits_d[k];
        sat_q[k]  <= sat_d[k];
      end
      meta_q[0] <= meta_i;
      for (int k = 1; k < STAGES; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
      out_mag_q  <= mag_d;
      out_meta_q <= meta_q[STAGES-1];
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  always_comb begin
    rounded = {1'b0, st_q[STAGES-1].root};
    if (sgm_pkg::PIX_W'(st_q[STAGES-1].rem) > st_q[STAGES-1].root ||
        st_q[STAGES-1].rem[sgm_pkg::REM_W-1:sgm_pkg::PIX_W] != '0) begin
      rounded = rounded + (sgm_pkg::PIX_W+1)'(1);
    end
    if (sat_q[STAGES-1] || rounded[sgm_pkg::PIX_W]) begin
      mag_d = sgm_pkg::MAG_MAX;
    end else begin
      mag_d = rounded[sgm_pkg::PIX_W-1:0];
    end
  end

  assign vld_o  = out_vld_q;
  assign mag_o  = out_mag_q;
  assign meta_o = out_meta_q;

endmodule

FILE: test/sgm_gradient_sb_pkg.sv
// Scoreboard that predicts and checks the gradient results of the Sobel core.
package sgm_gradient_sb_pkg;

  typedef struct packed {
    logic [sgm_pkg::POS_W-1:0] column;
    logic [sgm_pkg::POS_W-1:0] row;
    logic [sgm_pkg::PIX_W-1:0] magnitude;
    logic [sgm_pkg::PIX_W-1:0] center_alpha;
    logic                      frame_end;
  } gradient_t;

  localparam int unsigned REPORT_LIMIT = 10;

  function automatic int unsigned size_in_use(logic [sgm_pkg::CFG_W-1:0] raw,
                                              int unsigned max_size);
    if (raw < 3) return 3;
    if (raw > max_size) return max_size;
    return 32'(raw);
  endfunction

  class gradient_scoreboard;
    logic [sgm_pkg::CFG_W-1:0]   width_reg;
    logic [sgm_pkg::CFG_W-1:0]   height_reg;
    logic [3*sgm_pkg::PIX_W-1:0] line_mem [sgm_pkg::MAX_WIDTH];
    logic [sgm_pkg::PIX_W-1:0]   gray_win [3][3];
    logic [sgm_pkg::PIX_W-1:0]   alpha_win [3];
    int unsigned                 col;
    int unsigned                 row;
    int unsigned                 seen;
    int unsigned                 errors;
    gradient_t                   due_gradients [$];

    function new();
      width_reg  = sgm_pkg::WIDTH_RESET;
      height_reg = sgm_pkg::HEIGHT_RESET;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (gray_win[i, j]) gray_win[i][j] = '0;
      foreach (alpha_win[i]) alpha_win[i] = '0;
      col    = 0;
      row    = 0;
      seen   = 0;
      errors = 0;
    endfunction

    function void write_register(logic [sgm_pkg::IDX_W-1:0] index,
                                 logic [sgm_pkg::CFG_W-1:0] value);
      case (index)
        sgm_pkg::CFG_FRAME_WIDTH: width_reg = value;
        sgm_pkg::CFG_FRAME_HEIGHT: height_reg = value;
        default: ;
      endcase
    endfunction

    function int unsigned rounded_root(int unsigned sum);
      int unsigned n;
      n = 0;
      while (n < 256 && (n + 1) * (n + 1) <= sum) n++;
      if (sum - n * n > n) n++;
      return (n > 255) ? 255 : n;
    endfunction

    function void take_pixel(logic [sgm_pkg::PIX_W-1:0] red, logic [sgm_pkg::PIX_W-1:0] green,
                             logic [sgm_pkg::PIX_W-1:0] blue, logic [sgm_pkg::PIX_W-1:0] alpha);
      int unsigned                 w;
      int unsigned                 h;
      int unsigned                 gray;
      logic [3*sgm_pkg::PIX_W-1:0] prev;
      int                          gx;
      int                          gy;
      gradient_t                   g;
      w    = size_in_use(width_reg, sgm_pkg::MAX_WIDTH);
      h    = size_in_use(height_reg, sgm_pkg::MAX_HEIGHT);
      gray = (red + green + blue + 1) / 3;
      prev = (row == 0) ? '0 : line_mem[col];
      for (int i = 0; i < 3; i++) begin
        gray_win[i][0] = gray_win[i][1];
        gray_win[i][1] = gray_win[i][2];
      end
      gray_win[0][2] = prev[2*sgm_pkg::PIX_W-1:sgm_pkg::PIX_W];
      gray_win[1][2] = prev[sgm_pkg::PIX_W-1:0];
      gray_win[2][2] = sgm_pkg::PIX_W'(gray);
      alpha_win[0] = alpha_win[1];
      alpha_win[1] = alpha_win[2];
      alpha_win[2] = prev[3*sgm_pkg::PIX_W-1:2*sgm_pkg::PIX_W];
      line_mem[col] = {alpha, prev[sgm_pkg::PIX_W-1:0], sgm_pkg::PIX_W'(gray)};
      if (row >= 2 && col >= 2) begin
        gx = int'(gray_win[0][2]) + 2 * int'(gray_win[1][2]) + int'(gray_win[2][2])
           - int'(gray_win[0][0]) - 2 * int'(gray_win[1][0]) - int'(gray_win[2][0]);
        gy = int'(gray_win[0][0]) + 2 * int'(gray_win[0][1]) + int'(gray_win[0][2])
           - int'(gray_win[2][0]) - 2 * int'(gray_win[2][1]) - int'(gray_win[2][2]);
        g.column       = sgm_pkg::POS_W'(col - 1);
        g.row          = sgm_pkg::POS_W'(row - 1);
        g.magnitude    = sgm_pkg::PIX_W'(rounded_root(gx * gx + gy * gy));
        g.center_alpha = alpha_win[1];
        g.frame_end    = (col >= w - 1 && row >= h - 1);
        due_gradients.push_back(g);
      end
      if (col >= w - 1) begin
        col = 0;
        row = (row >= h - 1) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function void match_gradient(gradient_t got);
      gradient_t want;
      seen++;
      if (due_gradients.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("result %0d arrived with nothing expected: column %0d row %0d magnitude %0d",
                   seen, got.column, got.row, got.magnitude);
        end
        return;
      end
      want = due_gradients.pop_front();
      if (got.column !== want.column || got.row !== want.row ||
          got.magnitude !== want.magnitude || got.center_alpha !== want.center_alpha ||
          got.frame_end !== want.frame_end) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("result %0d mismatch, expected/actual: column %0d/%0d row %0d/%0d", seen,
                   want.column, got.column, want.row, got.row);
          $display("  magnitude %0d/%0d center_alpha %0d/%0d frame_end %0d/%0d",
                   want.magnitude, got.magnitude, want.center_alpha, got.center_alpha,
                   want.frame_end, got.frame_end);
        end
      end
    endfunction

    function int unsigned outstanding();
      return due_gradients.size();
    endfunction
  endclass

endpackage

FILE: test/tb.sv
// Self-checking testbench of the Sobel gradient magnitude core with random frames and stalls.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT        = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned WIDE_ITEMS   = sgm_pkg::MAX_WIDTH + 8;
  localparam int unsigned TALL_ITEMS   = 120;
  localparam int unsigned RANDOM_ITEMS = 800;

  localparam logic [sgm_pkg::IDX_W-1:0] CFG_SPARE_A = sgm_pkg::IDX_W'(2);
  localparam logic [sgm_pkg::IDX_W-1:0] CFG_SPARE_B = sgm_pkg::IDX_W'(3);

  typedef enum int unsigned {PACE_STEADY, PACE_BUSY, PACE_SPARSE} pace_e;
  typedef enum int unsigned {STYLE_NOISE, STYLE_EXTREME, STYLE_SMOOTH} pixel_style_e;

  logic                                    clk;
  logic                                    rst_n;
  int unsigned                             cycles = 0;
  pace_e                                   src_mode;
  pace_e                                   sink_mode;
  logic [sgm_pkg::PIX_W-1:0]               base;
  sgm_gradient_sb_pkg::gradient_scoreboard sb;

  sgm_pix_if pix ();
  sgm_res_if res ();
  sgm_cfg_if cfg ();

  sobel_gradient_magnitude_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_gap(pace_e mode);
    case (mode)
      PACE_BUSY: return $urandom_range(0, 11);
      PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      default: return 0;
    endcase
  endfunction

  function automatic logic [sgm_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return sgm_pkg::CFG_W'($urandom_range(0, 2));
      1: return sgm_pkg::CFG_W'($urandom_range(13, 40));
      default: return sgm_pkg::CFG_W'($urandom_range(3, 8));
    endcase
  endfunction

  always @(posedge clk) begin : observe
    sgm_gradient_sb_pkg::gradient_t got;
    cycles++;
    if (rst_n) begin
      if (cfg.valid && cfg.ready) sb.write_register(cfg.index, cfg.data);
      if (pix.valid && pix.ready) sb.take_pixel(pix.red, pix.green, pix.blue, pix.alpha);
      if (res.valid && res.ready) begin
        got.column       = res.column;
        got.row          = res.row;
        got.magnitude    = res.magnitude;
        got.center_alpha = res.center_alpha;
        got.frame_end    = res.frame_end;
        sb.match_gradient(got);
      end
    end
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned gap;
    res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(sink_mode);
      if (gap != 0) begin
        res.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      res.ready = 1'b1;
      @(posedge clk);
      while (!res.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_pixel(logic [sgm_pkg::PIX_W-1:0] r, logic [sgm_pkg::PIX_W-1:0] g,
                            logic [sgm_pkg::PIX_W-1:0] b, logic [sgm_pkg::PIX_W-1:0] a);
    int unsigned gap;
    gap = draw_gap(src_mode);
    if (gap != 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix.red   = r;
    pix.green = g;
    pix.blue  = b;
    pix.alpha = a;
    pix.valid = 1'b1;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [sgm_pkg::IDX_W-1:0] index, logic [sgm_pkg::CFG_W-1:0] value);
    cfg.index = index;
    cfg.data  = value;
    cfg.valid = 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic settle();
    pix.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_pixels(int unsigned count, pixel_style_e style);
    logic [sgm_pkg::PIX_W-1:0] r;
    logic [sgm_pkg::PIX_W-1:0] g;
    logic [sgm_pkg::PIX_W-1:0] b;
    logic [sgm_pkg::PIX_W-1:0] v;
    for (int unsigned n = 0; n < count; n++) begin
      r = sgm_pkg::PIX_W'($urandom);
      g = sgm_pkg::PIX_W'($urandom);
      b = sgm_pkg::PIX_W'($urandom);
      case (style)
        STYLE_EXTREME: begin
          if ($urandom_range(0, 3) != 0) begin
            v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            r = v;
            g = v;
            b = v;
          end else begin
            r = {sgm_pkg::PIX_W{r[0]}};
            g = {sgm_pkg::PIX_W{g[0]}};
            b = {sgm_pkg::PIX_W{b[0]}};
          end
        end
        STYLE_SMOOTH: begin
          v = (base > 8'd247) ? base - 8'($urandom_range(0, 8)) : base + 8'($urandom_range(0, 8));
          r = v;
          g = v;
          b = v;
        end
        default: ;
      endcase
      if (src_mode != PACE_STEADY && $urandom_range(0, 99) == 0) settle();
      send_pixel(r, g, b, 8'($urandom));
    end
  endtask

  initial begin
    int unsigned               random_items;
    int unsigned               count;
    int unsigned               w;
    int unsigned               h;
    logic [sgm_pkg::CFG_W-1:0] wraw;
    logic [sgm_pkg::CFG_W-1:0] hraw;
    logic [sgm_pkg::PIX_W-1:0] v;
    sb = new();
    rst_n     = 1'b0;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    pix.alpha = '0;
    cfg.valid = 1'b0;
    cfg.index = sgm_pkg::CFG_FRAME_WIDTH;
    cfg.data  = '0;
    src_mode  = PACE_STEADY;
    sink_mode = PACE_STEADY;
    base      = '0;
    random_items = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_reg(sgm_pkg::CFG_FRAME_WIDTH, sgm_pkg::CFG_W'(3));
    write_reg(sgm_pkg::CFG_FRAME_HEIGHT, sgm_pkg::CFG_W'(3));
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, sgm_pkg::CFG_W'(1));
    src_mode  = PACE_BUSY;
    sink_mode = PACE_BUSY;
    // A hard vertical edge saturates, a flat white frame gives zero, a faint
    // bottom row checks the rounding of the gray conversion.
    for (int i = 0; i < 9; i++) begin
      v = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'h80 : 8'hFF;
      send_pixel(v, v, v, 8'h5A ^ 8'(i));
    end
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    for (int i = 0; i < 9; i++) begin
      if (i < 6) send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
      else send_pixel(8'h02, 8'h00, 8'h00, 8'h00);
    end

    settle();
    write_reg(sgm_pkg::CFG_FRAME_WIDTH, '1);
    write_reg(sgm_pkg::CFG_FRAME_HEIGHT, sgm_pkg::CFG_W'(2));
    src_mode  = PACE_SPARSE;
    sink_mode = PACE_STEADY;
    run_pixels(WIDE_ITEMS, STYLE_NOISE);
    settle();
    write_reg(sgm_pkg::CFG_FRAME_WIDTH, sgm_pkg::CFG_W'(1));
    write_reg(sgm_pkg::CFG_FRAME_HEIGHT, '1);
    src_mode  = PACE_STEADY;
    sink_mode = PACE_SPARSE;
    run_pixels(TALL_ITEMS, STYLE_EXTREME);

    while (random_items < RANDOM_ITEMS) begin
      settle();
      wraw = pick_size();
      hraw = pick_size();
      // Growing the width part way down a frame would read columns never stored.
      if (sb.row != 0 && sgm_gradient_sb_pkg::size_in_use(wraw, sgm_pkg::MAX_WIDTH) >
          sgm_gradient_sb_pkg::size_in_use(sb.width_reg, sgm_pkg::MAX_WIDTH)) begin
        wraw = sb.width_reg;
      end
      write_reg(sgm_pkg::CFG_FRAME_WIDTH, wraw);
      write_reg(sgm_pkg::CFG_FRAME_HEIGHT, hraw);
      if ($urandom_range(0, 7) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, sgm_pkg::CFG_W'($urandom));
      end
      src_mode  = pace_e'($urandom_range(0, 2));
      sink_mode = pace_e'($urandom_range(0, 2));
      base      = sgm_pkg::PIX_W'($urandom);
      w = sgm_gradient_sb_pkg::size_in_use(wraw, sgm_pkg::MAX_WIDTH);
      h = sgm_gradient_sb_pkg::size_in_use(hraw, sgm_pkg::MAX_HEIGHT);
      if ($urandom_range(0, 2) == 0) count = $urandom_range(1, 2 * w * h);
      else count = w * h * $urandom_range(1, 2);
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      run_pixels(count, pixel_style_e'($urandom_range(0, 2)));
      random_items += count;
    end

    settle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
